// ===== design/bpc_pkg.sv =====
// bpc_pkg: shared types and constants of the barometric pressure compensation block
// used by bpc_ctrl, bpc_datapath and baro_pressure_compensation
// no dependencies
`default_nettype none

package bpc_pkg;

  // field widths
  localparam int RAW_W   = 24;
  localparam int CAL_W   = 16;
  localparam int TEMP_W  = 15;
  localparam int PRESS_W = 17;

  // configuration port
  localparam int APB_AW = 5;
  localparam int APB_DW = 32;

  // register indexes
  localparam logic [2:0] REG_MODE     = 3'd0;
  localparam logic [2:0] REG_SENS     = 3'd1;
  localparam logic [2:0] REG_OFFSET   = 3'd2;
  localparam logic [2:0] REG_TCS      = 3'd3;
  localparam logic [2:0] REG_TCO      = 3'd4;
  localparam logic [2:0] REG_TREF     = 3'd5;
  localparam logic [2:0] REG_TEMPSENS = 3'd6;

  // sequencer steps, also the controller state codes
  localparam logic [3:0] ST_IDLE  = 4'd0;   // wait for a word
  localparam logic [3:0] ST_DTEMP = 4'd1;   // temperature difference
  localparam logic [3:0] ST_MULT  = 4'd2;   // dtemp * tempsens
  localparam logic [3:0] ST_TC    = 4'd3;   // first order temperature
  localparam logic [3:0] ST_OFF   = 4'd4;   // first order offset
  localparam logic [3:0] ST_SENS  = 4'd5;   // first order sensitivity
  localparam logic [3:0] ST_LO    = 4'd6;   // keep low temperature square
  localparam logic [3:0] ST_CT    = 4'd7;   // keep temperature correction
  localparam logic [3:0] ST_CORR  = 4'd8;   // second order corrections
  localparam logic [3:0] ST_APPLY = 4'd9;   // apply corrections
  localparam logic [3:0] ST_PLO   = 4'd10;  // pressure product, low half
  localparam logic [3:0] ST_PHI   = 4'd11;  // pressure product, high half
  localparam logic [3:0] ST_PACC  = 4'd12;  // combine halves
  localparam logic [3:0] ST_PQ    = 4'd13;  // scale and remove offset
  localparam logic [3:0] ST_CHECK = 4'd14;  // final scale and bounds check
  localparam logic [3:0] ST_DONE  = 4'd15;  // hand result to the output register

  typedef struct packed {
    logic             mode;
    logic [CAL_W-1:0] sens;
    logic [CAL_W-1:0] offset;
    logic [CAL_W-1:0] tcs;
    logic [CAL_W-1:0] tco;
    logic [CAL_W-1:0] tref;
    logic [CAL_W-1:0] tempsens;
  } cal_t;

  typedef struct packed {
    logic       load;
    logic [3:0] step;
    logic       publish;
  } cmd_t;

endpackage

`default_nettype wire

// ===== design/baro_pressure_compensation.sv =====
// Barometric pressure compensation, top level: configuration registers and stream ports.
// One word at a time: a new input word is taken only after the last one has run through the
// whole step sequence on the one shared multiplier and been handed to the output register.
// A waiting output word does not block the next input word; a stalled output holds the sequencer.
// Reset (synchronous, active high) clears registers, last valid result and handshake state.
// depends on bpc_pkg, bpc_ctrl, bpc_datapath
`default_nettype none

module baro_pressure_compensation (
  input  wire logic                         clk,
  input  wire logic                         rst,
  // configuration port
  input  wire logic                         psel,
  input  wire logic                         penable,
  input  wire logic                         pwrite,
  input  wire logic [bpc_pkg::APB_AW-1:0]   paddr,
  input  wire logic [bpc_pkg::APB_DW-1:0]   pwdata,
  output logic [bpc_pkg::APB_DW-1:0]        prdata,
  output logic                              pready,
  // input stream
  input  wire logic                         s_tvalid,
  output logic                              s_tready,
  input  wire logic [47:0]                  s_tdata,  // raw_pressure, raw_temperature
  // output stream
  output logic                              m_tvalid,
  input  wire logic                         m_tready,
  output logic [31:0]                       m_tdata,  // temp_centideg, pressure_pa
  output logic                              m_tuser   // valid_res
);

  bpc_pkg::cal_t cal;
  bpc_pkg::cmd_t cmd;
  logic          wr_en;
  logic [2:0]    reg_idx;

  logic signed [bpc_pkg::TEMP_W-1:0] temp_centideg;
  logic [bpc_pkg::PRESS_W-1:0]       pressure_pa;
  logic                              valid_res;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite && pready;
  assign reg_idx = paddr[4:2];

  // register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      cal <= '0;
    end else if (wr_en) begin
      unique case (reg_idx)
        bpc_pkg::REG_MODE:     cal.mode     <= pwdata[0];
        bpc_pkg::REG_SENS:     cal.sens     <= pwdata[15:0];
        bpc_pkg::REG_OFFSET:   cal.offset   <= pwdata[15:0];
        bpc_pkg::REG_TCS:      cal.tcs      <= pwdata[15:0];
        bpc_pkg::REG_TCO:      cal.tco      <= pwdata[15:0];
        bpc_pkg::REG_TREF:     cal.tref     <= pwdata[15:0];
        bpc_pkg::REG_TEMPSENS: cal.tempsens <= pwdata[15:0];
        default: begin
        end
      endcase
    end
  end

  // register reads
  always_comb begin
    unique case (reg_idx)
      bpc_pkg::REG_MODE:     prdata = {31'b0, cal.mode};
      bpc_pkg::REG_SENS:     prdata = {16'b0, cal.sens};
      bpc_pkg::REG_OFFSET:   prdata = {16'b0, cal.offset};
      bpc_pkg::REG_TCS:      prdata = {16'b0, cal.tcs};
      bpc_pkg::REG_TCO:      prdata = {16'b0, cal.tco};
      bpc_pkg::REG_TREF:     prdata = {16'b0, cal.tref};
      bpc_pkg::REG_TEMPSENS: prdata = {16'b0, cal.tempsens};
      default:               prdata = '0;
    endcase
  end

  bpc_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .cmd       (cmd)
  );

  bpc_datapath u_datapath (
    .clk             (clk),
    .rst             (rst),
    .cmd             (cmd),
    .cal             (cal),
    .raw_pressure    (s_tdata[23:0]),
    .raw_temperature (s_tdata[47:24]),
    .temp_centideg   (temp_centideg),
    .pressure_pa     (pressure_pa),
    .valid_res       (valid_res)
  );

  // output word packing
  assign m_tdata = {pressure_pa, temp_centideg};
  assign m_tuser = valid_res;

endmodule

`default_nettype wire

// ===== design/bpc_ctrl.sv =====
// bpc_ctrl: sequencer of the compensation datapath and stream handshakes
// depends on bpc_pkg
`default_nettype none

module bpc_ctrl (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  wire logic         out_ready,
  output bpc_pkg::cmd_t     cmd
);

  logic [3:0] state;
  logic [3:0] state_next;
  logic       out_valid_next;

  // commands follow the state directly
  always_comb begin
    in_ready    = !rst && (state == bpc_pkg::ST_IDLE);
    cmd.load    = in_valid && in_ready;
    cmd.step    = state;
    cmd.publish = (state == bpc_pkg::ST_DONE) && (!out_valid || out_ready);
  end

  // step sequence
  always_comb begin
    unique case (state)
      bpc_pkg::ST_IDLE: state_next = cmd.load ? bpc_pkg::ST_DTEMP : bpc_pkg::ST_IDLE;
      bpc_pkg::ST_DONE: state_next = cmd.publish ? bpc_pkg::ST_IDLE : bpc_pkg::ST_DONE;
      default:          state_next = state + 4'd1;
    endcase
  end

  // output word valid flag
  always_comb begin
    if (cmd.publish) begin
      out_valid_next = 1'b1;
    end else if (out_ready) begin
      out_valid_next = 1'b0;
    end else begin
      out_valid_next = out_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= bpc_pkg::ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

endmodule

`default_nettype wire

// ===== design/bpc_datapath.sv =====
// bpc_datapath: shared multiplier, working registers and result registers
// depends on bpc_pkg; steered by bpc_ctrl
`default_nettype none

module bpc_datapath (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire bpc_pkg::cmd_t                 cmd,
  input  wire bpc_pkg::cal_t                 cal,
  input  wire logic [bpc_pkg::RAW_W-1:0]     raw_pressure,
  input  wire logic [bpc_pkg::RAW_W-1:0]     raw_temperature,
  output logic signed [bpc_pkg::TEMP_W-1:0]  temp_centideg,
  output logic [bpc_pkg::PRESS_W-1:0]        pressure_pa,
  output logic                               valid_res
);

  // signed division by 2**k truncating toward zero
  function automatic logic signed [63:0] sdiv_pow2(input logic signed [63:0] x,
                                                   input logic [4:0] k);
    logic signed [63:0] bias;
    bias = x[63] ? ((64'sd1 <<< k) - 64'sd1) : 64'sd0;
    return (x + bias) >>> k;
  endfunction

  logic [bpc_pkg::RAW_W-1:0] rawp;
  logic [bpc_pkg::RAW_W-1:0] rawt;
  logic signed [24:0]        dtemp;
  logic signed [19:0]        tc;
  logic signed [41:0]        off;
  logic signed [41:0]        sens;
  logic [34:0]               lo;
  logic [16:0]               corr_t;
  logic [41:0]               corr_o;
  logic [41:0]               corr_s;
  logic signed [63:0]        acc;
  logic signed [43:0]        q;
  logic signed [bpc_pkg::TEMP_W-1:0]  last_temp;
  logic [bpc_pkg::PRESS_W-1:0]        last_press;
  logic                               res_valid;

  logic signed [25:0] mul_a;
  logic signed [25:0] mul_b;
  logic signed [51:0] prod;

  logic signed [63:0] p64;
  logic signed [20:0] tc_m2000;
  logic signed [20:0] tc_p1500;
  logic               below_2000;
  logic               below_1500;
  logic signed [41:0] base_off;
  logic signed [41:0] base_sens;
  logic [4:0]         k_off;
  logic [4:0]         k_sens;
  logic signed [63:0] off_step;
  logic signed [63:0] sens_step;
  logic [41:0]        lo42;
  logic [41:0]        vlo42;
  logic [41:0]        co_next;
  logic [41:0]        cs_next;
  logic signed [63:0] t64;
  logic signed [63:0] q64;
  logic signed [63:0] pa64;
  logic [31:0]        pa32;
  logic               in_bounds;

  // helpers
  always_comb begin
    p64        = {{12{prod[51]}}, prod};
    tc_m2000   = {tc[19], tc} - 21'sd2000;
    tc_p1500   = {tc[19], tc} + 21'sd1500;
    below_2000 = (tc < 20'sd2000);
    below_1500 = (tc < -20'sd1500);
    base_off   = cal.mode ? $signed({9'b0, cal.offset, 17'b0})
                          : $signed({10'b0, cal.offset, 16'b0});
    base_sens  = cal.mode ? $signed({10'b0, cal.sens, 16'b0})
                          : $signed({11'b0, cal.sens, 15'b0});
    k_off      = cal.mode ? 5'd6 : 5'd7;
    k_sens     = cal.mode ? 5'd7 : 5'd8;
    off_step   = sdiv_pow2(p64, k_off);
    sens_step  = sdiv_pow2(p64, k_sens);
    lo42       = {7'b0, lo};
    vlo42      = {7'b0, prod[34:0]};
    t64        = 64'sd2000 + sdiv_pow2(p64, 5'd23);
    q64        = sdiv_pow2(acc, 5'd21) - {{22{off[41]}}, off};
    pa64       = sdiv_pow2({{20{q[43]}}, q}, 5'd15);
    pa32       = pa64[31:0];
    in_bounds  = (tc > -20'sd4000) && (tc < 20'sd8500) &&
                 (pa32 > 32'd1000) && (pa32 < 32'd120000);
  end

  // second order correction terms
  always_comb begin
    if (cal.mode) begin
      co_next = ((lo42 * 42'd61) >> 4) + (below_1500 ? vlo42 * 42'd15 : 42'd0);
      cs_next = (lo42 << 1) + (below_1500 ? (vlo42 << 3) : 42'd0);
    end else begin
      co_next = ((lo42 * 42'd5) >> 1) + (below_1500 ? vlo42 * 42'd7 : 42'd0);
      cs_next = ((lo42 * 42'd5) >> 2) + (below_1500 ? ((vlo42 * 42'd11) >> 1) : 42'd0);
    end
  end

  // shared multiplier operands
  always_comb begin
    unique case (cmd.step)
      bpc_pkg::ST_MULT: begin
        mul_a = {dtemp[24], dtemp};
        mul_b = $signed({10'b0, cal.tempsens});
      end
      bpc_pkg::ST_TC: begin
        mul_a = {dtemp[24], dtemp};
        mul_b = $signed({10'b0, cal.tco});
      end
      bpc_pkg::ST_OFF: begin
        mul_a = {dtemp[24], dtemp};
        mul_b = $signed({10'b0, cal.tcs});
      end
      bpc_pkg::ST_SENS: begin
        mul_a = {{5{tc_m2000[20]}}, tc_m2000};
        mul_b = {{5{tc_m2000[20]}}, tc_m2000};
      end
      bpc_pkg::ST_LO: begin
        mul_a = {dtemp[24], dtemp};
        mul_b = {dtemp[24], dtemp};
      end
      bpc_pkg::ST_CT: begin
        mul_a = {{5{tc_p1500[20]}}, tc_p1500};
        mul_b = {{5{tc_p1500[20]}}, tc_p1500};
      end
      bpc_pkg::ST_PLO: begin
        mul_a = $signed({2'b0, rawp});
        mul_b = $signed({5'b0, sens[20:0]});
      end
      bpc_pkg::ST_PHI: begin
        mul_a = $signed({2'b0, rawp});
        mul_b = {{5{sens[41]}}, sens[41:21]};
      end
      default: begin
        mul_a = 26'sd0;
        mul_b = 26'sd0;
      end
    endcase
  end

  // product register
  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;
  end

  // working registers, one step per cycle unless the sequencer waits in idle or done
  always_ff @(posedge clk) begin
    unique case (cmd.step)
      bpc_pkg::ST_IDLE: begin
        if (cmd.load) begin
          rawp <= raw_pressure;
          rawt <= raw_temperature;
        end
      end
      bpc_pkg::ST_DTEMP: dtemp <= $signed({1'b0, rawt}) - $signed({1'b0, cal.tref, 8'h00});
      bpc_pkg::ST_TC:    tc    <= t64[19:0];
      bpc_pkg::ST_OFF: begin
        off <= base_off + off_step[41:0];
      end
      bpc_pkg::ST_SENS: begin
        sens <= base_sens + sens_step[41:0];
      end
      bpc_pkg::ST_LO:    lo     <= prod[34:0];
      bpc_pkg::ST_CT:    corr_t <= prod[47:31];
      bpc_pkg::ST_CORR: begin
        corr_o <= co_next;
        corr_s <= cs_next;
      end
      bpc_pkg::ST_APPLY: begin
        if (below_2000) begin
          tc   <= tc - $signed({3'b0, corr_t});
          off  <= off - $signed(corr_o);
          sens <= sens - $signed(corr_s);
        end
      end
      bpc_pkg::ST_PHI:  acc <= p64;
      bpc_pkg::ST_PACC: acc <= acc + (p64 <<< 21);
      bpc_pkg::ST_PQ:   q   <= q64[43:0];
      default: begin
      end
    endcase
  end

  // last valid result, kept across words
  always_ff @(posedge clk) begin
    if (rst) begin
      last_temp  <= '0;
      last_press <= '0;
    end else if (cmd.step == bpc_pkg::ST_CHECK && in_bounds) begin
      last_temp  <= tc[bpc_pkg::TEMP_W-1:0];
      last_press <= pa32[bpc_pkg::PRESS_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.step == bpc_pkg::ST_CHECK) begin
      res_valid <= in_bounds;
    end
  end

  // output word register
  always_ff @(posedge clk) begin
    if (cmd.publish) begin
      temp_centideg <= last_temp;
      pressure_pa   <= last_press;
      valid_res     <= res_valid;
    end
  end

endmodule

`default_nettype wire

// ===== tb/baro_comp_checker.sv =====
// baro_comp_checker: watches the register port and both streams of the pressure compensation
// block, predicts every result word and compares it with what the block hands out
// depends on bpc_pkg
`timescale 1ns / 1ps

module baro_comp_checker
  import bpc_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                psel,
  input  wire logic                penable,
  input  wire logic                pwrite,
  input  wire logic                pready,
  input  wire logic [APB_AW-1:0]   paddr,
  input  wire logic [APB_DW-1:0]   pwdata,
  input  wire logic                s_tvalid,
  input  wire logic                s_tready,
  input  wire logic [47:0]         s_tdata,   // raw_pressure, raw_temperature
  input  wire logic                m_tvalid,
  input  wire logic                m_tready,
  input  wire logic [31:0]         m_tdata,   // temp_centideg, pressure_pa
  input  wire logic                m_tuser,   // valid_res
  output int                       mismatch_total,
  output int                       readings_due
);

  // acceptance window of a compensated reading
  localparam longint TEMP_FLOOR = -4000;
  localparam longint TEMP_CEIL  = 8500;
  localparam logic [31:0] PRESS_FLOOR = 32'd1000;
  localparam logic [31:0] PRESS_CEIL  = 32'd120000;
  localparam longint SQ_DIV = 64'sd2147483648;

  typedef struct packed {
    logic signed [63:0] temp;
    logic [31:0]        press;
  } comp_t;

  typedef struct packed {
    logic signed [TEMP_W-1:0] temp;
    logic [PRESS_W-1:0]       press;
    logic                     ok;
  } reading_t;

  cal_t                     regs;
  logic signed [TEMP_W-1:0] held_temp;
  logic [PRESS_W-1:0]       held_press;
  reading_t                 expected_readings[$];
  int                       mismatches = 0;

  assign mismatch_total = mismatches;

  // first and second order compensation of one conversion pair
  function automatic comp_t compensate(input logic [RAW_W-1:0] raw_p,
                                       input logic [RAW_W-1:0] raw_t);
    longint d_t, t_c, off_acc, sens_acc, sq_lo, sq_vlo, fix_t, fix_off, fix_sens, scaled;
    comp_t res;
    d_t = longint'(raw_t) - longint'(regs.tref) * 256;
    t_c = 2000 + (d_t * longint'(regs.tempsens)) / 8388608;
    if (regs.mode) begin
      off_acc  = longint'(regs.offset) * 131072 + (longint'(regs.tco) * d_t) / 64;
      sens_acc = longint'(regs.sens) * 65536 + (longint'(regs.tcs) * d_t) / 128;
    end else begin
      off_acc  = longint'(regs.offset) * 65536 + (longint'(regs.tco) * d_t) / 128;
      sens_acc = longint'(regs.sens) * 32768 + (longint'(regs.tcs) * d_t) / 256;
    end
    // second order terms below 20 degC, extra terms below -15 degC
    if (t_c < 2000) begin
      sq_lo = (t_c - 2000) * (t_c - 2000);
      fix_t = (d_t * d_t) / SQ_DIV;
      if (regs.mode) begin
        fix_off  = (61 * sq_lo) / 16;
        fix_sens = 2 * sq_lo;
      end else begin
        fix_off  = (5 * sq_lo) / 2;
        fix_sens = (5 * sq_lo) / 4;
      end
      if (t_c < -1500) begin
        sq_vlo = (t_c + 1500) * (t_c + 1500);
        if (regs.mode) begin
          fix_off  = fix_off + 15 * sq_vlo;
          fix_sens = fix_sens + 8 * sq_vlo;
        end else begin
          fix_off  = fix_off + 7 * sq_vlo;
          fix_sens = fix_sens + (11 * sq_vlo) / 2;
        end
      end
      t_c      = t_c - fix_t;
      off_acc  = off_acc - fix_off;
      sens_acc = sens_acc - fix_sens;
    end
    scaled    = ((longint'(raw_p) * sens_acc) / 2097152 - off_acc) / 32768;
    res.temp  = t_c;
    res.press = scaled[31:0];
    return res;
  endfunction

  always @(posedge clk) begin : watch
    reading_t want;
    comp_t    calc;
    if (rst) begin
      regs       = '0;
      held_temp  = '0;
      held_press = '0;
      expected_readings.delete();
    end else begin
      // register writes
      if (psel && penable && pwrite && pready) begin
        case (paddr[4:2])
          REG_MODE:     regs.mode     = pwdata[0];
          REG_SENS:     regs.sens     = pwdata[CAL_W-1:0];
          REG_OFFSET:   regs.offset   = pwdata[CAL_W-1:0];
          REG_TCS:      regs.tcs      = pwdata[CAL_W-1:0];
          REG_TCO:      regs.tco      = pwdata[CAL_W-1:0];
          REG_TREF:     regs.tref     = pwdata[CAL_W-1:0];
          REG_TEMPSENS: regs.tempsens = pwdata[CAL_W-1:0];
          default: ;
        endcase
      end
      // compare an outgoing word with the oldest prediction
      if (m_tvalid && m_tready) begin
        if (expected_readings.size() == 0) begin
          $error("result word with no prediction outstanding");
          mismatches++;
        end else begin
          want = expected_readings.pop_front();
          if (m_tdata[TEMP_W-1:0] !== want.temp) begin
            $error("temp_centideg: expected %0d, got %0d",
                   want.temp, $signed(m_tdata[TEMP_W-1:0]));
            mismatches++;
          end
          if (m_tdata[TEMP_W+PRESS_W-1:TEMP_W] !== want.press) begin
            $error("pressure_pa: expected %0d, got %0d",
                   want.press, m_tdata[TEMP_W+PRESS_W-1:TEMP_W]);
            mismatches++;
          end
          if (m_tuser !== want.ok) begin
            $error("valid_res: expected %0d, got %0d", want.ok, m_tuser);
            mismatches++;
          end
        end
      end
      // predict the word for an accepted conversion pair
      if (s_tvalid && s_tready) begin
        calc    = compensate(s_tdata[RAW_W-1:0], s_tdata[2*RAW_W-1:RAW_W]);
        want.ok = calc.temp > TEMP_FLOOR && calc.temp < TEMP_CEIL &&
                  calc.press > PRESS_FLOOR && calc.press < PRESS_CEIL;
        if (want.ok) begin
          held_temp  = calc.temp[TEMP_W-1:0];
          held_press = calc.press[PRESS_W-1:0];
        end
        want.temp  = held_temp;
        want.press = held_press;
        expected_readings.push_back(want);
      end
    end
    readings_due <= expected_readings.size();
  end

endmodule

// ===== tb/tb.sv =====
// tb: drives calibration writes and raw conversion pairs into the pressure compensation block
// with random gaps and output stalls, and gives the verdict from baro_comp_checker
// depends on bpc_pkg, baro_pressure_compensation, baro_comp_checker
`timescale 1ns / 1ps

module tb;
  import bpc_pkg::*;

  localparam logic [2:0]       REG_UNUSED = 3'd7;
  localparam logic [RAW_W-1:0] RAW_TOP    = '1;
  localparam longint           RAW_LIMIT  = 16777215;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              psel, penable, pwrite;
  logic [APB_AW-1:0] paddr;
  logic [APB_DW-1:0] pwdata;
  logic [APB_DW-1:0] prdata;
  logic              pready;
  logic              s_tvalid, s_tready;
  logic [47:0]       s_tdata;   // raw_pressure, raw_temperature
  logic              m_tvalid, m_tready;
  logic [31:0]       m_tdata;   // temp_centideg, pressure_pa
  logic              m_tuser;   // valid_res
  int                mismatch_total, readings_due;

  // idling knobs, one per side
  bit tx_calm = 1'b1;
  bit rx_calm = 1'b1;

  // calibration currently loaded, used to aim raw temperatures
  cal_t cur_cal = '0;
  cal_t sheet_cal;
  int   temp_marks [8] = '{8499, 8500, 2000, 1999, -1500, -1501, -3900, -4000};

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  baro_pressure_compensation dut (
    .clk(clk), .rst(rst),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata),
    .prdata(prdata), .pready(pready),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
  );

  baro_comp_checker chk (
    .clk(clk), .rst(rst),
    .psel(psel), .penable(penable), .pwrite(pwrite), .pready(pready),
    .paddr(paddr), .pwdata(pwdata),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .mismatch_total(mismatch_total), .readings_due(readings_due)
  );

  // one register write, setup then access; the bus is left selected for the next one
  task automatic write_reg(input logic [2:0] idx, input logic [CAL_W-1:0] val);
    logic [APB_DW-1:0] word;
    word = {{(APB_DW-CAL_W){1'b0}}, val};
    if ($urandom_range(0, 1) == 1) word[APB_DW-1:CAL_W] = (APB_DW-CAL_W)'($urandom());
    if (idx == REG_MODE && $urandom_range(0, 1) == 1) word[CAL_W-1:1] = (CAL_W-1)'($urandom());
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= word;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (pready !== 1'b1);
  endtask

  // full calibration set plus a write to the unused index
  task automatic load_cal(input cal_t cal);
    write_reg(REG_MODE, {{(CAL_W-1){1'b0}}, cal.mode});
    write_reg(REG_SENS, cal.sens);
    write_reg(REG_OFFSET, cal.offset);
    write_reg(REG_TCS, cal.tcs);
    write_reg(REG_TCO, cal.tco);
    write_reg(REG_TREF, cal.tref);
    write_reg(REG_TEMPSENS, cal.tempsens);
    write_reg(REG_UNUSED, CAL_W'($urandom()));
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    cur_cal = cal;
  endtask

  // one conversion pair, after a random gap unless the sender runs calm
  task automatic send_word(input logic [RAW_W-1:0] raw_p, input logic [RAW_W-1:0] raw_t);
    int gap;
    gap = tx_calm ? 0 : int'($urandom_range(0, 13));
    if (gap != 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {raw_t, raw_p};
    do @(posedge clk); while (s_tready !== 1'b1);
  endtask

  // hold the input until every predicted word has come out
  task automatic settle();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (readings_due != 0) @(posedge clk);
  endtask

  // raw temperature whose first order result is the target, unless clamped or tempsens is 0
  function automatic logic [RAW_W-1:0] raw_for_temp(input int target);
    longint span, steps;
    if (cur_cal.tempsens == 0) return RAW_W'($urandom());
    span  = longint'(target - 2000) * 8388608;
    steps = ((span < 0 ? -span : span) + longint'(cur_cal.tempsens) - 1) /
            longint'(cur_cal.tempsens);
    if (span < 0) steps = -steps;
    steps = steps + longint'(cur_cal.tref) * 256;
    if (steps < 0) steps = 0;
    else if (steps > RAW_LIMIT) steps = RAW_LIMIT;
    return steps[RAW_W-1:0];
  endfunction

  // calibration word scattered around a typical value
  function automatic logic [CAL_W-1:0] jitter(input int base);
    int v;
    v = base * int'($urandom_range(75, 125)) / 100;
    return (v > 65535) ? '1 : CAL_W'(v);
  endfunction

  // output side: either always ready, or waits a random stall once a word shows up
  initial begin : rx_side
    int stall;
    forever begin
      stall = rx_calm ? 0 : int'($urandom_range(0, 13));
      if (stall == 0) begin
        m_tready <= 1'b1;
      end else begin
        m_tready <= 1'b0;
        do @(posedge clk); while (m_tvalid !== 1'b1);
        repeat (stall) @(posedge clk);
        m_tready <= 1'b1;
      end
      do @(posedge clk); while (m_tvalid !== 1'b1);
    end
  end

  initial begin : stimulus
    int rnd, target, count;
    logic [RAW_W-1:0] rp, rt;
    cal_t cal;
    psel     <= 1'b0;
    penable  <= 1'b0;
    pwrite   <= 1'b0;
    paddr    <= '0;
    pwdata   <= '0;
    s_tvalid <= 1'b0;
    s_tdata  <= '0;
    sheet_cal = '{mode: 1'b0, sens: 16'd40127, offset: 16'd36924, tcs: 16'd23317,
                  tco: 16'd23282, tref: 16'd33464, tempsens: 16'd28312};
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // calibration still at reset: nothing passes, held values stay zero
    send_word('0, '0);
    send_word(RAW_TOP, RAW_TOP);
    settle();

    // typical sensor, full resolution
    load_cal(sheet_cal);
    send_word(24'd9085466, 24'd8569150);
    send_word('0, raw_for_temp(2500));       // negative pressure wraps and fails
    send_word(RAW_TOP, raw_for_temp(2500));  // pressure far above range
    foreach (temp_marks[i]) send_word(24'd9085466, raw_for_temp(temp_marks[i]));
    send_word(RAW_TOP, RAW_TOP);
    send_word('0, '0);
    settle();

    // half resolution constants: the first word again, then two colder words
    sheet_cal.mode = 1'b1;
    load_cal(sheet_cal);
    send_word(24'd9085466, 24'd8569150);
    send_word(24'd4500000, raw_for_temp(500));
    send_word(24'd4500000, raw_for_temp(-2500));
    settle();

    // random phases, each with its own calibration
    for (int ph = 0; ph < 10; ph++) begin
      if (ph == 0) begin
        sheet_cal.mode = 1'b0;
        cal = sheet_cal;
      end else if (ph == 1) begin
        sheet_cal.mode = 1'b1;
        cal = sheet_cal;
      end else if (ph == 2) begin
        cal = '1;
      end else if (ph == 3) begin
        cal = '0;
      end else begin
        cal.mode     = 1'($urandom_range(0, 1));
        cal.sens     = jitter(40127);
        cal.offset   = jitter(36924);
        cal.tcs      = jitter(23317);
        cal.tco      = jitter(23282);
        cal.tref     = jitter(33464);
        cal.tempsens = jitter(28312);
      end
      load_cal(cal);
      tx_calm = (ph == 0) || ($urandom_range(0, 3) == 0);
      rx_calm = (ph == 0) || ($urandom_range(0, 3) == 0);
      count = (ph == 2 || ph == 3) ? 40 : 90;
      for (int n = 0; n < count; n++) begin
        if (n == 45 && (ph == 0 || $urandom_range(0, 2) == 0)) settle();
        // aim at the interesting temperatures, near the bounds now and then
        rnd = $urandom_range(0, 99);
        if (rnd < 20) target = temp_marks[$urandom_range(0, 7)] + int'($urandom_range(0, 6)) - 3;
        else target = int'($urandom_range(0, 16000)) - 6000;
        rnd = $urandom_range(0, 99);
        if (rnd < 70) begin
          rt = raw_for_temp(target);
          rp = RAW_W'($urandom_range(2000000, 12000000));
        end else if (rnd < 85) begin
          rt = raw_for_temp(target);
          rp = RAW_W'($urandom());
        end else begin
          rt = RAW_W'($urandom());
          rp = RAW_W'($urandom());
        end
        send_word(rp, rt);
      end
      settle();
    end

    repeat (20) @(posedge clk);
    if (mismatch_total == 0 && readings_due == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  // watchdog
  initial begin
    #5000000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule

// ===== files.f =====
design/bpc_pkg.sv
design/bpc_ctrl.sv
design/bpc_datapath.sv
design/baro_pressure_compensation.sv
tb/baro_comp_checker.sv
tb/tb.sv
